[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks are sampled on clk and disabled while rst_n is low.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/ttlsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ttlsr_pkg;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_GLYPH = 2'd1;
    localparam logic [1:0] OP_PIXEL = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] REG_BG     = 2'd0;
    localparam logic [1:0] REG_TEXT   = 2'd1;
    localparam logic [1:0] REG_TITLE  = 2'd2;
    localparam logic [1:0] REG_CURSOR = 2'd3;

    localparam logic [7:0] CH_BS = 8'd8;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;

    localparam int FIRST_CHAR = 32;
    localparam int END_CHAR   = 127;
    localparam int GLYPHS     = END_CHAR - FIRST_CHAR;
    localparam int FONT_ROWS  = 16;
    localparam int FONT_DEPTH = GLYPHS * FONT_ROWS;
    localparam int FAW        = $clog2(FONT_DEPTH);

    localparam logic [31:0] BG_RESET     = 32'h0000_0000;
    localparam logic [31:0] TEXT_RESET   = 32'h00FF_FFFF;
    localparam logic [31:0] TITLE_RESET  = 32'h0040_4040;
    localparam logic [31:0] CURSOR_RESET = 32'h00FF_FFFF;

    typedef struct packed {
        logic clr;
        logic accept;
        logic exec;
        logic div1;
        logic div2;
        logic line;
        logic addr;
        logic glyph;
        logic fin;
        logic load_out;
    } ttlsr_cmd_t;

    typedef struct packed {
        logic clr_last;
    } ttlsr_status_t;

endpackage
`default_nettype wire

[sv/ttlsr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ttlsr_ctrl
    import ttlsr_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    operation,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire ttlsr_status_t status,
    output ttlsr_cmd_t         cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_EXEC  = 4'd2;
    localparam logic [3:0] S_DIV1  = 4'd3;
    localparam logic [3:0] S_DIV2  = 4'd4;
    localparam logic [3:0] S_LINE  = 4'd5;
    localparam logic [3:0] S_ADDR  = 4'd6;
    localparam logic [3:0] S_GLYPH = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.accept     = accept;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (status.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                    state_next = (operation == OP_PIXEL) ? S_DIV1 : S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_DONE;
            end
            S_DIV1:
            begin
                cmd.div1   = 1'b1;
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                cmd.div2   = 1'b1;
                state_next = S_LINE;
            end
            S_LINE:
            begin
                cmd.line   = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = S_GLYPH;
            end
            S_GLYPH:
            begin
                cmd.glyph  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_NEXT(a_done_loads, state_reg == S_DONE && !out_valid_reg, out_valid_reg, "result not loaded")
    `ASSERT_ALWAYS(a_one_step, $onehot0({cmd.clr, cmd.exec, cmd.div1, cmd.div2, cmd.line, cmd.addr, cmd.glyph, cmd.fin, cmd.load_out}), "several datapath steps at once")
    `ASSERT_IMPL(a_no_accept_clear, state_reg == S_CLEAR, !in_ready, "word taken during font clear")

endmodule
`default_nettype wire

[sv/ttlsr_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ttlsr_dp
    import ttlsr_pkg::*;
#(
    parameter int LINES      = 32,
    parameter int COLS       = 80,
    parameter int WIDTH      = 640,
    parameter int HEIGHT     = 480,
    parameter int GLYPH_H    = 16,
    parameter int TITLE_ROWS = 24
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ttlsr_cmd_t    cmd,
    output ttlsr_status_t      status,
    input  wire logic [1:0]    operation,
    input  wire logic [7:0]    char_code,
    input  wire logic [3:0]    glyph_row,
    input  wire logic [7:0]    glyph_bits,
    input  wire logic [9:0]    pixel_x,
    input  wire logic [8:0]    pixel_y,
    input  wire logic          cfg_wr,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data,
    output logic [31:0]        pixel_color,
    output logic [5:0]         line_count,
    output logic [6:0]         cursor_column
);

    localparam int LW    = $clog2(LINES);
    localparam int HW    = $clog2(LINES + 1);
    localparam int CAW   = $clog2(LINES * COLS);
    localparam int AW    = 11;
    localparam int VIS_R = (HEIGHT > TITLE_ROWS) ? (HEIGHT - TITLE_ROWS) / GLYPH_H : 0;
    localparam int VIS   = (VIS_R > LINES) ? LINES : VIS_R;
    localparam int RECIP = 65536 / GLYPH_H;

    logic [31:0] bg_reg, text_reg, title_reg, cursor_reg;

    logic [1:0]  op_reg;
    logic [7:0]  code_reg;
    logic [3:0]  row_in_reg;
    logic [7:0]  bits_reg;
    logic [9:0]  x_reg;
    logic [8:0]  y_reg;

    logic [HW-1:0] held_reg;
    logic [LW-1:0] base_reg;
    logic [6:0]    cur_len_reg;
    logic [6:0]    line_len_reg [LINES];

    logic [FAW-1:0] clr_reg;

    logic [6:0]  char_mem [LINES * COLS];
    logic [7:0]  font_mem [FONT_DEPTH];

    logic        outside_reg, title_hit_reg;
    logic [8:0]  yt_reg, q0_reg;
    logic [9:0]  row_reg;
    logic [3:0]  gy_reg;
    logic        show_reg, is_last_reg;
    logic [LW-1:0] line_reg;
    logic        in_text_reg, at_cursor_reg;
    logic [6:0]  char_q;
    logic [7:0]  font_q;
    logic [31:0] color_reg;

    function automatic logic [LW-1:0] wrap(input logic [LW:0] s);
        wrap = (s >= (LW+1)'(LINES)) ? LW'(s - (LW+1)'(LINES)) : LW'(s);
    endfunction

    logic [LW-1:0] last_phys, new_phys, base_inc, eff_phys, pix_phys;
    logic [6:0]    eff_len, pix_len;
    logic          is_nl, is_bs, is_print, full;
    logic          char_we, font_we;
    logic [CAW-1:0] char_waddr, char_raddr;
    logic [FAW-1:0] font_waddr, font_raddr;
    logic [7:0]     font_wdata;
    logic [12:0]   yt13;
    logic [25:0]   prod;
    logic [13:0]   qg, rem;
    logic [AW-1:0] first, line_full;
    logic [6:0]    col;

    assign status.clr_last = (clr_reg == FAW'(FONT_DEPTH - 1));

    assign last_phys = wrap((LW+1)'(base_reg) + (LW+1)'(held_reg - HW'(1)));
    assign new_phys  = wrap((LW+1)'(base_reg) + (LW+1)'(held_reg));
    assign base_inc  = wrap((LW+1)'(base_reg) + (LW+1)'(1));
    assign full      = (held_reg == HW'(LINES));
    assign eff_len   = (held_reg == '0) ? 7'd0 : cur_len_reg;
    assign eff_phys  = (held_reg == '0) ? base_reg : last_phys;
    assign is_nl     = (code_reg == CH_LF) || (code_reg == CH_CR);
    assign is_bs     = (code_reg == CH_BS);
    assign is_print  = (code_reg >= 8'(FIRST_CHAR)) && (code_reg < 8'(END_CHAR));

    assign char_we    = cmd.exec && (op_reg == OP_PUT) && !is_nl && !is_bs && is_print
                        && (eff_len < 7'(COLS));
    assign char_waddr = CAW'(eff_phys * COLS + int'(eff_len));

    assign font_we    = cmd.clr || (cmd.exec && (op_reg == OP_GLYPH) && is_print
                        && ({1'b0, row_in_reg} < 5'(GLYPH_H)));
    assign font_waddr = cmd.clr ? clr_reg : FAW'({7'(code_reg - 8'(FIRST_CHAR)), row_in_reg});
    assign font_wdata = cmd.clr ? 8'd0 : bits_reg;

    assign yt13 = 13'(y_reg) - 13'(TITLE_ROWS);
    assign prod = 26'(yt13[8:0]) * 26'(RECIP);
    assign qg   = 14'(q0_reg) * 14'(GLYPH_H);
    assign rem  = 14'(yt_reg) - qg;

    assign first     = (AW'(held_reg) > AW'(VIS)) ? AW'(held_reg) - AW'(VIS) : '0;
    assign line_full = first + AW'(row_reg);

    assign col        = x_reg[9:3];
    assign pix_phys   = wrap((LW+1)'(base_reg) + (LW+1)'(line_reg));
    assign pix_len    = line_len_reg[pix_phys];
    assign char_raddr = CAW'(pix_phys * COLS + int'(col));
    assign font_raddr = FAW'({7'(char_q - 7'(FIRST_CHAR)), gy_reg});

    always_ff @(posedge clk)
    begin
        if (char_we)
            char_mem[char_waddr] <= code_reg[6:0];
        if (cmd.addr)
            char_q <= char_mem[char_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (font_we)
            font_mem[font_waddr] <= font_wdata;
        if (cmd.glyph)
            font_q <= font_mem[font_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= operation;
            code_reg   <= char_code;
            row_in_reg <= glyph_row;
            bits_reg   <= glyph_bits;
            x_reg      <= pixel_x;
            y_reg      <= pixel_y;
        end
        if (cmd.div1)
        begin
            outside_reg   <= (13'(x_reg) >= 13'(WIDTH)) || (13'(y_reg) >= 13'(HEIGHT));
            title_hit_reg <= (13'(y_reg) < 13'(TITLE_ROWS));
            yt_reg        <= yt13[8:0];
            q0_reg        <= prod[24:16];
        end
        if (cmd.div2)
        begin
            if (rem >= 14'(GLYPH_H))
            begin
                row_reg <= 10'(q0_reg) + 10'd1;
                gy_reg  <= 4'(rem - 14'(GLYPH_H));
            end
            else
            begin
                row_reg <= 10'(q0_reg);
                gy_reg  <= 4'(rem);
            end
        end
        if (cmd.line)
        begin
            show_reg    <= (AW'(row_reg) < AW'(VIS)) && (line_full < AW'(held_reg));
            is_last_reg <= (line_full == AW'(held_reg) - AW'(1));
            line_reg    <= LW'(line_full);
        end
        if (cmd.addr)
        begin
            in_text_reg   <= (col < pix_len);
            at_cursor_reg <= is_last_reg && (col == pix_len);
        end
        if (cmd.exec)
            color_reg <= '0;
        if (cmd.fin)
        begin
            if (outside_reg)
                color_reg <= '0;
            else if (title_hit_reg)
                color_reg <= title_reg;
            else if (!show_reg)
                color_reg <= bg_reg;
            else if (in_text_reg)
                color_reg <= ((char_q >= 7'(FIRST_CHAR)) && (char_q < 7'(END_CHAR))
                              && font_q[~x_reg[2:0]]) ? text_reg : bg_reg;
            else if (at_cursor_reg)
                color_reg <= cursor_reg;
            else
                color_reg <= bg_reg;
        end
        if (cmd.load_out)
        begin
            pixel_color   <= color_reg;
            line_count    <= 6'(held_reg);
            cursor_column <= cur_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_reg      <= BG_RESET;
            text_reg    <= TEXT_RESET;
            title_reg   <= TITLE_RESET;
            cursor_reg  <= CURSOR_RESET;
            clr_reg     <= '0;
            held_reg    <= '0;
            base_reg    <= '0;
            cur_len_reg <= '0;
            for (int i = 0; i < LINES; i++)
                line_len_reg[i] <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    REG_BG:     bg_reg     <= cfg_data;
                    REG_TEXT:   text_reg   <= cfg_data;
                    REG_TITLE:  title_reg  <= cfg_data;
                    REG_CURSOR: cursor_reg <= cfg_data;
                    default:    bg_reg     <= bg_reg;
                endcase
            end
            if (cmd.clr)
                clr_reg <= clr_reg + FAW'(1);
            if (cmd.exec && (op_reg == OP_PUT))
            begin
                if (is_nl)
                begin
                    cur_len_reg <= '0;
                    if (full)
                    begin
                        line_len_reg[base_reg] <= '0;
                        base_reg               <= base_inc;
                    end
                    else
                    begin
                        line_len_reg[new_phys] <= '0;
                        held_reg               <= held_reg + HW'(1);
                    end
                end
                else if (is_bs)
                begin
                    if ((held_reg != '0) && (cur_len_reg != '0))
                    begin
                        cur_len_reg             <= cur_len_reg - 7'd1;
                        line_len_reg[last_phys] <= cur_len_reg - 7'd1;
                    end
                end
                else if (is_print)
                begin
                    if (held_reg == '0)
                        held_reg <= HW'(1);
                    if (eff_len < 7'(COLS))
                    begin
                        cur_len_reg            <= eff_len + 7'd1;
                        line_len_reg[eff_phys] <= eff_len + 7'd1;
                    end
                    else
                    begin
                        cur_len_reg <= eff_len;
                    end
                end
            end
        end
    end

    `ASSERT_ALWAYS(a_held_range, held_reg <= HW'(LINES), "line count above store depth")
    `ASSERT_ALWAYS(a_len_range, cur_len_reg <= 7'(COLS), "line length above column count")
    `ASSERT_IMPL(a_empty_len, held_reg == '0, cur_len_reg == '0, "cursor moved with no line held")

endmodule
`default_nettype wire

[sv/text_terminal_line_store_renderer.sv]
// channel | direction | handshake            | word
// in      | in        | in_valid / in_ready   | operation, char_code, glyph_row, glyph_bits,
//         |           |                       | pixel_x, pixel_y
// out     | out       | out_valid / out_ready | pixel_color, line_count, cursor_column
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// One word at a time. Put character, glyph load and unused codes: an execute step, then
// the result is loaded; pixel read: divide by glyph height, line length lookup, then
// dependent synchronous reads of the character store and the font store, then the load.
// The next word is taken only after the result of the last one is loaded.
// After reset the font store is cleared one entry a cycle, 1520 entries with in_ready low.
// A new word is taken while a result still waits on out_ready.
`timescale 1ns / 1ps
`default_nettype none
module text_terminal_line_store_renderer
    import ttlsr_pkg::*;
#(
    parameter int LINES      = 32,
    parameter int COLS       = 80,
    parameter int WIDTH      = 640,
    parameter int HEIGHT     = 480,
    parameter int GLYPH_H    = 16,
    parameter int TITLE_ROWS = 24
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  char_code,
    input  wire logic [3:0]  glyph_row,
    input  wire logic [7:0]  glyph_bits,
    input  wire logic [9:0]  pixel_x,
    input  wire logic [8:0]  pixel_y,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      pixel_color,
    output logic [5:0]       line_count,
    output logic [6:0]       cursor_column,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    ttlsr_cmd_t    cmd;
    ttlsr_status_t status;

    assign cfg_ready = 1'b1;

    ttlsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ttlsr_dp #(
        .LINES      (LINES),
        .COLS       (COLS),
        .WIDTH      (WIDTH),
        .HEIGHT     (HEIGHT),
        .GLYPH_H    (GLYPH_H),
        .TITLE_ROWS (TITLE_ROWS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .operation     (operation),
        .char_code     (char_code),
        .glyph_row     (glyph_row),
        .glyph_bits    (glyph_bits),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_color   (pixel_color),
        .line_count    (line_count),
        .cursor_column (cursor_column)
    );

endmodule
`default_nettype wire
